>>> design/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg: shared types and constants for the grid max path sum block
// Field widths, the saturation limit and the per-cell control bundle.
// ----------------------------------------------------------------------------
package gmps_pkg;

  localparam int VALUE_W = 16;
  localparam int TOTAL_W = 32;
  localparam int CFG_W   = 7;

  localparam logic [CFG_W-1:0]   CFG_ROWS_RESET = 7'd64;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = '1;

  // Per-cell control that travels with an item into the sum stage
  typedef struct packed {
    logic first_col;  // first column of the grid: no neighbors
    logic has_up;     // row above exists
    logic has_down;   // row below exists
    logic clamp;      // row count lowered mid-column, cell forced to last row
    logic last;       // final cell of the grid
    logic last_row;   // cell ends its column
  } cell_ctl_t;

endpackage

>>> design/gmps_ram.sv
// ----------------------------------------------------------------------------
// gmps_ram: generic RAM, one write port and two registered read ports
// Read data updates only when rd_en is high and holds otherwise.
// ----------------------------------------------------------------------------
module gmps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> design/gmps_sum.sv
// ----------------------------------------------------------------------------
// gmps_sum: cell total and running column maximum
// Picks the best neighbor total, adds the cell value with saturation and
// folds the result into the column maximum.
// ----------------------------------------------------------------------------
module gmps_sum (
  input  logic [gmps_pkg::VALUE_W-1:0] value,
  input  gmps_pkg::cell_ctl_t          ctl,
  input  logic [gmps_pkg::TOTAL_W-1:0] nbr_same,
  input  logic [gmps_pkg::TOTAL_W-1:0] nbr_up,
  input  logic [gmps_pkg::TOTAL_W-1:0] nbr_down,
  input  logic [gmps_pkg::TOTAL_W-1:0] col_max,
  output logic [gmps_pkg::TOTAL_W-1:0] total,
  output logic [gmps_pkg::TOTAL_W-1:0] col_max_new
);
  import gmps_pkg::*;

  logic [TOTAL_W-1:0] up_term;
  logic [TOTAL_W-1:0] down_term;
  logic [TOTAL_W-1:0] best_ud;
  logic [TOTAL_W-1:0] best;
  logic [TOTAL_W:0]   sum;

  // Missing neighbors count as zero, which never wins a max of unsigned totals
  assign up_term   = ctl.has_up   ? nbr_up   : '0;
  assign down_term = ctl.has_down ? nbr_down : '0;
  assign best_ud   = (up_term > down_term) ? up_term : down_term;

  always_comb begin
    if (ctl.first_col) begin
      best = '0;
    end else if (nbr_same > best_ud) begin
      best = nbr_same;
    end else begin
      best = best_ud;
    end
  end

  assign sum         = {1'b0, best} + (TOTAL_W + 1)'(value);
  assign total       = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign col_max_new = (total > col_max) ? total : col_max;

endmodule

>>> design/grid_max_path_sum.sv
// ----------------------------------------------------------------------------
// grid_max_path_sum: streaming gold mine best-path accumulator
// Pipeline: an accepted cell is registered into the sum stage and summed there;
//   the grid result is then registered into the output register for m_tvalid.
// Throughput: one cell per cycle; input stalls only while a finished result
//   is held in the output register and the next one is ready to leave.
// Reset clears the row position, column flag, column maximum and output valid;
//   the column total RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module grid_max_path_sum #(
  parameter int ROWS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  // config: rows_in_use
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [gmps_pkg::CFG_W-1:0]   cfg_data,
  // input items
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,  // [15:0] cell_value
  input  logic                         s_tlast,  // last_in_grid
  // result items
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata   // [31:0] best_total
);
  import gmps_pkg::*;

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = ($clog2(ROWS + 1) > CFG_W) ? $clog2(ROWS + 1) : CFG_W;
  localparam int AW = RW + 1;   // {bank, row}

  // Control state
  logic [CFG_W-1:0]   rows_in_use;
  logic [RW-1:0]      row_position;
  logic               first_column;
  logic               cur_bank;
  logic [TOTAL_W-1:0] column_maximum;

  // Sum stage
  logic               s1_valid;
  logic [VALUE_W-1:0] s1_value;
  cell_ctl_t          s1_ctl;
  logic [AW-1:0]      s1_wr_addr;
  logic               fwd_a;
  logic               fwd_b;
  logic [TOTAL_W-1:0] fwd_data;
  logic [TOTAL_W-1:0] win;

  // Output register
  logic               out_valid;
  logic [TOTAL_W-1:0] out_data;

  logic               stall;
  logic               accept;
  logic               s1_fire;
  logic [CW-1:0]      cfg_ext;
  logic [CW-1:0]      rows_eff;
  logic [CW-1:0]      rows_m1;
  logic [CW-1:0]      pos_ext;
  logic               clamp;
  logic [RW-1:0]      row;
  logic               last_row;
  logic [RW-1:0]      row_b;
  logic [AW-1:0]      rd_addr_a;
  logic [AW-1:0]      rd_addr_b;
  logic [TOTAL_W-1:0] rd_data_a;
  logic [TOTAL_W-1:0] rd_data_b;
  logic [TOTAL_W-1:0] prev_a;
  logic [TOTAL_W-1:0] prev_b;
  logic [TOTAL_W-1:0] nbr_up;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] col_max_new;
  cell_ctl_t          in_ctl;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rows_in_use <= cfg_data;
    end
  end

  // Effective row count and the row this cell lands on
  always_comb begin
    cfg_ext = CW'(rows_in_use);
    if (cfg_ext == '0) begin
      rows_eff = CW'(1);
    end else if (cfg_ext > CW'(ROWS)) begin
      rows_eff = CW'(ROWS);
    end else begin
      rows_eff = cfg_ext;
    end
  end

  assign rows_m1  = rows_eff - CW'(1);
  assign pos_ext  = CW'(row_position);
  assign clamp    = pos_ext > rows_m1;
  assign row      = clamp ? rows_m1[RW-1:0] : row_position;
  assign last_row = clamp || (pos_ext == rows_m1);

  // Port B fetches the row below, or the row above when the row is clamped
  // (the window register then holds the wrong row).
  assign row_b     = clamp ? (row - RW'(1)) : (row + RW'(1));
  assign rd_addr_a = {~cur_bank, row};
  assign rd_addr_b = {~cur_bank, row_b};

  always_comb begin
    in_ctl.first_col = first_column;
    in_ctl.has_up    = row != '0;
    in_ctl.has_down  = !last_row;
    in_ctl.clamp     = clamp;
    in_ctl.last      = s_tlast;
    in_ctl.last_row  = last_row;
  end

  assign stall    = s1_valid && s1_ctl.last && out_valid && !m_tready;
  assign s_tready = !stall;
  assign accept   = s_tvalid && s_tready;
  assign s1_fire  = s1_valid && !stall;

  gmps_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (2 ** AW)
  ) u_ram (
    .clk       (clk),
    .wr_en     (s1_fire),
    .wr_addr   (s1_wr_addr),
    .wr_data   (total),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Same-cycle write bypass (shows up only with one or two rows)
  assign prev_a = fwd_a ? fwd_data : rd_data_a;
  assign prev_b = fwd_b ? fwd_data : rd_data_b;
  assign nbr_up = s1_ctl.clamp ? prev_b : win;

  gmps_sum u_sum (
    .value       (s1_value),
    .ctl         (s1_ctl),
    .nbr_same    (prev_a),
    .nbr_up      (nbr_up),
    .nbr_down    (prev_b),
    .col_max     (column_maximum),
    .total       (total),
    .col_max_new (col_max_new)
  );

  // Row sequencing and bank swap at accept time
  always_ff @(posedge clk) begin
    if (rst) begin
      row_position <= '0;
      first_column <= 1'b1;
      cur_bank     <= 1'b0;
      s1_valid     <= 1'b0;
      fwd_a        <= 1'b0;
      fwd_b        <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
      fwd_a    <= s1_fire && (s1_wr_addr == rd_addr_a);
      fwd_b    <= s1_fire && (s1_wr_addr == rd_addr_b);
      if (s_tlast) begin
        row_position <= '0;
        first_column <= 1'b1;
      end else if (last_row) begin
        row_position <= '0;
        first_column <= 1'b0;
        cur_bank     <= ~cur_bank;
      end else begin
        row_position <= row + RW'(1);
      end
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value   <= s_tdata[VALUE_W-1:0];
      s1_ctl     <= in_ctl;
      s1_wr_addr <= {cur_bank, row};
      fwd_data   <= total;
    end
    if (s1_fire) begin
      win <= prev_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_maximum <= '0;
    end else if (s1_fire) begin
      if (s1_ctl.last || s1_ctl.last_row) begin
        column_maximum <= '0;
      end else begin
        column_maximum <= col_max_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_ctl.last) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctl.last) begin
      out_data <= col_max_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    CW'(row_position) < CW'(ROWS))
    else $error("row position beyond storage depth");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_ctl.last) |=> (m_tvalid && m_tdata == $past(col_max_new)))
    else $error("grid result not loaded into output register");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (s1_valid && s1_ctl.last && m_tvalid))
    else $error("input stalled without a pending result");

  a_bank_swap: assert property (@(posedge clk) disable iff (rst)
    !(accept && last_row && !s_tlast) |=> (cur_bank == $past(cur_bank)))
    else $error("bank swapped outside a column end");

endmodule
